/* src/fti_pkg.sv */
// ----------------------------------------------------------------------------
// fti_pkg: shared types and constants of the two-input fuzzy inference block
// Register indexes, rule class codes and the region flags of one crisp input.
// ----------------------------------------------------------------------------
package fti_pkg;

    localparam int POINT_W     = 16;
    localparam int PRICE_W     = 20;
    localparam int PRICE_FRAC  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int RULE_MAP_W  = 18;
    localparam int NUM_RULES   = 9;
    localparam int NUM_SETS    = 3;
    localparam int NUM_CLASSES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_LOW           = 3'd0,
        REG_POINT_MID           = 3'd1,
        REG_POINT_HIGH          = 3'd2,
        REG_SINGLETON_CHEAP     = 3'd3,
        REG_SINGLETON_NORMAL    = 3'd4,
        REG_SINGLETON_EXPENSIVE = 3'd5,
        REG_RULE_MAP            = 3'd6
    } cfg_reg_t;

    localparam logic [1:0] CLASS_CHEAP     = 2'd0;
    localparam logic [1:0] CLASS_NORMAL    = 2'd1;
    localparam logic [1:0] CLASS_EXPENSIVE = 2'd2;
    localparam logic [1:0] CLASS_DISABLED  = 2'd3;

    // Position of a crisp input against the three break points.
    typedef struct packed {
        logic le_a;
        logic in_ab;
        logic ge_b;
        logic eq_b;
        logic in_bc;
        logic ge_c;
    } region_t;

endpackage

/* src/fti_div.sv */
// ----------------------------------------------------------------------------
// fti_div: pipelined restoring divider
// One quotient bit per register stage for several lanes that move together,
// with a side payload that travels alongside the quotient.
// ----------------------------------------------------------------------------
module fti_div #(
    parameter int RW    = 16,
    parameter int QW    = 12,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [LANES-1:0][RW-1:0]       in_rem,
    input  logic [LANES-1:0][QW-1:0]       in_low,
    input  logic [LANES-1:0][RW-1:0]       in_den,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][QW-1:0]       out_quot,
    output logic [SW-1:0]                  out_side
);

    logic [LANES-1:0][RW-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0] low_reg  [QW];
    logic [LANES-1:0][RW-1:0] den_reg  [QW];
    logic [LANES-1:0][QW-1:0] quot_reg [QW];
    logic [SW-1:0]            side_reg [QW];
    logic [QW-1:0]            valid_reg;

    logic [LANES-1:0][RW-1:0] rem_in   [QW];
    logic [LANES-1:0][QW-1:0] low_in   [QW];
    logic [LANES-1:0][RW-1:0] den_in   [QW];
    logic [LANES-1:0][QW-1:0] quot_in  [QW];
    logic [SW-1:0]            side_in  [QW];
    logic [QW-1:0]            valid_in;
    logic [LANES-1:0][RW-1:0] rem_next [QW];
    logic [LANES-1:0][QW-1:0] low_next [QW];
    logic [LANES-1:0][QW-1:0] quot_next[QW];

    genvar st, ln;
    generate
        for (st = 0; st < QW; st++) begin : g_stage
            if (st == 0) begin : g_first
                assign rem_in[st]   = in_rem;
                assign low_in[st]   = in_low;
                assign den_in[st]   = in_den;
                assign quot_in[st]  = '0;
                assign side_in[st]  = in_side;
                assign valid_in[st] = in_valid;
            end else begin : g_rest
                assign rem_in[st]   = rem_reg[st-1];
                assign low_in[st]   = low_reg[st-1];
                assign den_in[st]   = den_reg[st-1];
                assign quot_in[st]  = quot_reg[st-1];
                assign side_in[st]  = side_reg[st-1];
                assign valid_in[st] = valid_reg[st-1];
            end

            for (ln = 0; ln < LANES; ln++) begin : g_lane
                logic [RW:0] trial;
                always_comb begin
                    trial = {rem_in[st][ln], low_in[st][ln][QW-1]};
                    if (trial >= {1'b0, den_in[st][ln]}) begin
                        rem_next[st][ln]  = RW'(trial - {1'b0, den_in[st][ln]});
                        quot_next[st][ln] = {quot_in[st][ln][QW-2:0], 1'b1};
                    end else begin
                        rem_next[st][ln]  = trial[RW-1:0];
                        quot_next[st][ln] = {quot_in[st][ln][QW-2:0], 1'b0};
                    end
                    low_next[st][ln] = {low_in[st][ln][QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[st] <= 1'b0;
                end else if (adv) begin
                    valid_reg[st] <= valid_in[st];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[st]  <= rem_next[st];
                    low_reg[st]  <= low_next[st];
                    den_reg[st]  <= den_in[st];
                    quot_reg[st] <= quot_next[st];
                    side_reg[st] <= side_in[st];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

/* src/fti_front.sv */
// ----------------------------------------------------------------------------
// fti_front: fuzzifier front end for one crisp input
// Registers the region flags and the two slope numerators and span.
// ----------------------------------------------------------------------------
module fti_front (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [fti_pkg::POINT_W-1:0] x,
    input  logic [fti_pkg::POINT_W-1:0] point_a,
    input  logic [fti_pkg::POINT_W-1:0] point_b,
    input  logic [fti_pkg::POINT_W-1:0] point_c,
    output fti_pkg::region_t            region_reg,
    output logic [fti_pkg::POINT_W-1:0] num1_reg,
    output logic [fti_pkg::POINT_W-1:0] num2_reg,
    output logic [fti_pkg::POINT_W-1:0] span_reg
);

    fti_pkg::region_t            region_next;
    logic [fti_pkg::POINT_W-1:0] num1_next;
    logic [fti_pkg::POINT_W-1:0] num2_next;
    logic [fti_pkg::POINT_W-1:0] span_next;

    always_comb begin
        region_next.le_a  = (x <= point_a);
        region_next.in_ab = (x > point_a) && (x < point_b);
        region_next.ge_b  = (x >= point_b);
        region_next.eq_b  = (x == point_b);
        region_next.in_bc = (x > point_b) && (x < point_c);
        region_next.ge_c  = (x >= point_c);
        if (region_next.in_ab) begin
            num1_next = point_b - x;
            num2_next = x - point_a;
            span_next = point_b - point_a;
        end else begin
            num1_next = point_c - x;
            num2_next = x - point_b;
            span_next = point_c - point_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            region_reg <= region_next;
            num1_reg   <= num1_next;
            num2_reg   <= num2_next;
            span_reg   <= span_next;
        end
    end

endmodule

/* src/fti_infer.sv */
// ----------------------------------------------------------------------------
// fti_infer: rule evaluation and weighted sums
// Memberships and rule minimums, class maximums in two steps, products with
// the singletons beside the denominator sum, then the numerator sum.
// ----------------------------------------------------------------------------
module fti_infer #(
    parameter int FB = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  fti_pkg::region_t               stock_region,
    input  fti_pkg::region_t               demand_region,
    input  logic [1:0][FB-1:0]             stock_quot,
    input  logic [1:0][FB-1:0]             demand_quot,
    input  logic [fti_pkg::POINT_W-1:0]    singleton_cheap,
    input  logic [fti_pkg::POINT_W-1:0]    singleton_normal,
    input  logic [fti_pkg::POINT_W-1:0]    singleton_expensive,
    input  logic [fti_pkg::RULE_MAP_W-1:0] rule_map,
    output logic                           out_valid,
    output logic [FB+18:0]                 out_num,
    output logic [FB+1:0]                  out_den,
    output logic [2:0][FB:0]               out_cls
);

    localparam int MW = FB + 1;
    localparam logic [MW-1:0] ONE = MW'(1) << FB;

    logic [4:0]           valid_reg;
    logic [MW-1:0]        rule_reg   [fti_pkg::NUM_RULES];
    logic [MW-1:0]        part_reg   [fti_pkg::NUM_CLASSES][fti_pkg::NUM_SETS];
    logic [2:0][MW-1:0]   cls_reg;
    logic [2:0][MW-1:0]   cls2_reg;
    logic [FB+16:0]       prod_reg   [fti_pkg::NUM_CLASSES];
    logic [FB+1:0]        den_reg;
    logic [2:0][MW-1:0]   cls3_reg;
    logic [FB+18:0]       num_reg;
    logic [FB+1:0]        den2_reg;

    logic [MW-1:0] ms [fti_pkg::NUM_SETS];
    logic [MW-1:0] md [fti_pkg::NUM_SETS];
    logic [MW-1:0] rule_next [fti_pkg::NUM_RULES];
    logic [MW-1:0] part_next [fti_pkg::NUM_CLASSES][fti_pkg::NUM_SETS];
    logic [2:0][MW-1:0] cls_next;

    function automatic logic [MW-1:0] memb_left(fti_pkg::region_t r, logic [FB-1:0] q1);
        logic [MW-1:0] v;
        if (r.ge_b) v = '0;
        else if (r.in_ab) v = {1'b0, q1};
        else if (r.le_a) v = ONE;
        else v = '0;
        return v;
    endfunction

    function automatic logic [MW-1:0] memb_centre(fti_pkg::region_t r, logic [FB-1:0] q1,
                                                  logic [FB-1:0] q2);
        logic [MW-1:0] v;
        if (r.in_bc) v = {1'b0, q1};
        else if (r.eq_b) v = ONE;
        else if (r.in_ab) v = {1'b0, q2};
        else v = '0;
        return v;
    endfunction

    function automatic logic [MW-1:0] memb_right(fti_pkg::region_t r, logic [FB-1:0] q2);
        logic [MW-1:0] v;
        if (r.ge_c) v = ONE;
        else if (r.in_bc) v = {1'b0, q2};
        else v = '0;
        return v;
    endfunction

    always_comb begin
        ms[0] = memb_left(stock_region, stock_quot[0]);
        ms[1] = memb_centre(stock_region, stock_quot[0], stock_quot[1]);
        ms[2] = memb_right(stock_region, stock_quot[1]);
        md[0] = memb_left(demand_region, demand_quot[0]);
        md[1] = memb_centre(demand_region, demand_quot[0], demand_quot[1]);
        md[2] = memb_right(demand_region, demand_quot[1]);
        for (int s = 0; s < fti_pkg::NUM_SETS; s++) begin
            for (int d = 0; d < fti_pkg::NUM_SETS; d++) begin
                rule_next[3*s+d] = (ms[s] < md[d]) ? ms[s] : md[d];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < fti_pkg::NUM_CLASSES; k++) begin
            for (int s = 0; s < fti_pkg::NUM_SETS; s++) begin
                part_next[k][s] = '0;
                for (int d = 0; d < fti_pkg::NUM_SETS; d++) begin
                    if (rule_map[2*(3*s+d) +: 2] == 2'(k)
                            && rule_reg[3*s+d] > part_next[k][s]) begin
                        part_next[k][s] = rule_reg[3*s+d];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < fti_pkg::NUM_CLASSES; k++) begin
            cls_next[k] = part_reg[k][0];
            for (int s = 1; s < fti_pkg::NUM_SETS; s++) begin
                if (part_reg[k][s] > cls_next[k]) begin
                    cls_next[k] = part_reg[k][s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rule_reg    <= rule_next;
            part_reg    <= part_next;
            cls_reg     <= cls_next;
            prod_reg[0] <= singleton_cheap * cls_reg[0];
            prod_reg[1] <= singleton_normal * cls_reg[1];
            prod_reg[2] <= singleton_expensive * cls_reg[2];
            den_reg     <= (FB+2)'(cls_reg[0]) + (FB+2)'(cls_reg[1]) + (FB+2)'(cls_reg[2]);
            cls2_reg    <= cls_reg;
            num_reg     <= (FB+19)'(prod_reg[0]) + (FB+19)'(prod_reg[1])
                           + (FB+19)'(prod_reg[2]);
            den2_reg    <= den_reg;
            cls3_reg    <= cls2_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_num   = num_reg;
    assign out_den   = den2_reg;
    assign out_cls   = cls3_reg;

endmodule

/* src/fuzzy_two_input_inference.sv */
// ----------------------------------------------------------------------------
// fuzzy_two_input_inference: two-input max-min fuzzy price controller
// Fuzzifies stock and demand, runs nine min rules into three classes and
// returns the singleton-weighted average price with the class strengths.
// ----------------------------------------------------------------------------
// The block takes one stock/demand pair per cycle unless the pipeline holds,
// and returns one result per pair, in order. An input transfer passes the
// region registers, the pipelined membership divider (one quotient bit per
// stage), the rule evaluation and sum registers, the pipelined price divider
// (one quotient bit per stage) and one output register. When m_tready is low
// with a result waiting, the whole pipeline holds and s_tready drops.
// Configuration writes are taken at once.
module fuzzy_two_input_inference #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] stock_level, [31:16] demand_level
    input  logic [31:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // price, strength_cheap, strength_normal, strength_expensive, zero padding
    output logic [((fti_pkg::PRICE_W + 3 * (FRACTION_BITS + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // no_rule_fired
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fti_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [fti_pkg::RULE_MAP_W-1:0]  cfg_data
);

    localparam int FB      = FRACTION_BITS;
    localparam int SW_W    = FB + 1;
    localparam int DATA_W  = fti_pkg::PRICE_W + 3 * SW_W;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int PW      = fti_pkg::POINT_W;
    localparam int RGW     = $bits(fti_pkg::region_t);
    localparam int DVD_W   = FB + 19 + fti_pkg::PRICE_FRAC;
    localparam int PSIDE_W = 3 * SW_W + 1;

    logic [PW-1:0] point_low_reg, point_mid_reg, point_high_reg;
    logic [PW-1:0] sing_cheap_reg, sing_normal_reg, sing_exp_reg;
    logic [fti_pkg::RULE_MAP_W-1:0] rule_map_reg;

    logic adv;
    logic front_valid_reg;

    fti_pkg::region_t stock_region, demand_region;
    logic [PW-1:0] stock_num1, stock_num2, stock_span;
    logic [PW-1:0] demand_num1, demand_num2, demand_span;

    logic                      mdiv_valid;
    logic [3:0][FB-1:0]        mdiv_quot;
    logic [2*RGW-1:0]          mdiv_side;

    logic                      inf_valid;
    logic [FB+18:0]            inf_num;
    logic [FB+1:0]             inf_den;
    logic [2:0][FB:0]          inf_cls;

    logic [DVD_W-1:0]          dividend;
    logic                      pdiv_valid;
    logic [0:0][fti_pkg::PRICE_W-1:0] pdiv_quot;
    logic [PSIDE_W-1:0]        pdiv_side;

    logic                          m_tvalid_reg;
    logic [fti_pkg::PRICE_W-1:0]   price_reg;
    logic [2:0][FB:0]              strength_reg;
    logic                          none_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_low_reg   <= PW'(40);
            point_mid_reg   <= PW'(60);
            point_high_reg  <= PW'(80);
            sing_cheap_reg  <= PW'(20);
            sing_normal_reg <= PW'(60);
            sing_exp_reg    <= PW'(90);
            rule_map_reg    <= fti_pkg::RULE_MAP_W'(83040);
        end else if (cfg_valid) begin
            case (fti_pkg::cfg_reg_t'(cfg_addr))
                fti_pkg::REG_POINT_LOW:           point_low_reg   <= cfg_data[PW-1:0];
                fti_pkg::REG_POINT_MID:           point_mid_reg   <= cfg_data[PW-1:0];
                fti_pkg::REG_POINT_HIGH:          point_high_reg  <= cfg_data[PW-1:0];
                fti_pkg::REG_SINGLETON_CHEAP:     sing_cheap_reg  <= cfg_data[PW-1:0];
                fti_pkg::REG_SINGLETON_NORMAL:    sing_normal_reg <= cfg_data[PW-1:0];
                fti_pkg::REG_SINGLETON_EXPENSIVE: sing_exp_reg    <= cfg_data[PW-1:0];
                fti_pkg::REG_RULE_MAP:            rule_map_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= s_tvalid;
        end
    end

    fti_front u_front_stock (
        .aclk       (aclk),
        .adv        (adv),
        .x          (s_tdata[15:0]),
        .point_a    (point_low_reg),
        .point_b    (point_mid_reg),
        .point_c    (point_high_reg),
        .region_reg (stock_region),
        .num1_reg   (stock_num1),
        .num2_reg   (stock_num2),
        .span_reg   (stock_span)
    );

    fti_front u_front_demand (
        .aclk       (aclk),
        .adv        (adv),
        .x          (s_tdata[31:16]),
        .point_a    (point_low_reg),
        .point_b    (point_mid_reg),
        .point_c    (point_high_reg),
        .region_reg (demand_region),
        .num1_reg   (demand_num1),
        .num2_reg   (demand_num2),
        .span_reg   (demand_span)
    );

    fti_div #(
        .RW    (PW),
        .QW    (FB),
        .LANES (4),
        .SW    (2 * RGW)
    ) u_memb_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid_reg),
        .in_rem    ({demand_num2, demand_num1, stock_num2, stock_num1}),
        .in_low    ('0),
        .in_den    ({demand_span, demand_span, stock_span, stock_span}),
        .in_side   ({demand_region, stock_region}),
        .out_valid (mdiv_valid),
        .out_quot  (mdiv_quot),
        .out_side  (mdiv_side)
    );

    fti_infer #(
        .FB (FB)
    ) u_infer (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .adv                 (adv),
        .in_valid            (mdiv_valid),
        .stock_region        (fti_pkg::region_t'(mdiv_side[RGW-1:0])),
        .demand_region       (fti_pkg::region_t'(mdiv_side[2*RGW-1:RGW])),
        .stock_quot          ({mdiv_quot[1], mdiv_quot[0]}),
        .demand_quot         ({mdiv_quot[3], mdiv_quot[2]}),
        .singleton_cheap     (sing_cheap_reg),
        .singleton_normal    (sing_normal_reg),
        .singleton_expensive (sing_exp_reg),
        .rule_map            (rule_map_reg),
        .out_valid           (inf_valid),
        .out_num             (inf_num),
        .out_den             (inf_den),
        .out_cls             (inf_cls)
    );

    // The quotient is below 2^20, so the dividend's upper part is below the divisor.
    assign dividend = {inf_num, fti_pkg::PRICE_FRAC'(0)};

    fti_div #(
        .RW    (FB + 2),
        .QW    (fti_pkg::PRICE_W),
        .LANES (1),
        .SW    (PSIDE_W)
    ) u_price_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (inf_valid),
        .in_rem    (dividend[DVD_W-2:fti_pkg::PRICE_W]),
        .in_low    (dividend[fti_pkg::PRICE_W-1:0]),
        .in_den    (inf_den),
        .in_side   ({inf_cls, inf_den == '0}),
        .out_valid (pdiv_valid),
        .out_quot  (pdiv_quot),
        .out_side  (pdiv_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= pdiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            none_reg     <= pdiv_side[0];
            strength_reg <= pdiv_side[PSIDE_W-1:1];
            price_reg    <= pdiv_side[0] ? '0 : pdiv_quot[0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = none_reg;
    assign m_tdata  = TDATA_W'({strength_reg[2], strength_reg[1], strength_reg[0],
                                price_reg});

`ifndef SYNTHESIS
    a_none_price_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> price_reg == '0)
        else $error("price not zero with no rule fired");

    a_fired_has_strength: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (strength_reg[0] != '0 || strength_reg[1] != '0 || strength_reg[2] != '0))
        else $error("rule fired flag clear with all strengths zero");

    a_strength_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (strength_reg[0] <= ((FB+1)'(1) << FB))
                  && (strength_reg[1] <= ((FB+1)'(1) << FB))
                  && (strength_reg[2] <= ((FB+1)'(1) << FB)))
        else $error("class strength above one");
`endif

endmodule
